/* hdl/tlcg_pkg.sv */
`timescale 1ns / 1ps
package tlcg_pkg;

    localparam int TABLE_SIZE_DEF = 97;

    localparam int SEED_W      = 32;
    localparam int GEN_W       = 18;
    localparam int MUL_W       = 13;
    localparam int Y_W         = SEED_W + 1;
    localparam int Q_W         = 16;
    localparam int R_W         = GEN_W + 1;
    localparam int PROD_W      = Y_W + Q_W;
    localparam int ENTRY_W     = 36;
    localparam int FRAC_W      = 32;
    localparam int NUM_GEN     = 3;
    localparam int RECIP_SHIFT = Y_W;

    localparam int FRAC_R_W    = 17;
    localparam int FRAC_SHIFT  = ENTRY_W;
    localparam int FPROD_W     = ENTRY_W + FRAC_R_W;

    localparam int GEN1_IDX = 0;
    localparam int GEN2_IDX = 1;
    localparam int GEN3_IDX = 2;

    localparam longint unsigned M1 = 259200;
    localparam longint unsigned A1 = 7141;
    localparam longint unsigned C1 = 54773;
    localparam longint unsigned M2 = 134456;
    localparam longint unsigned A2 = 8121;
    localparam longint unsigned C2 = 28411;
    localparam longint unsigned M3 = 243000;
    localparam longint unsigned A3 = 4561;
    localparam longint unsigned C3 = 51349;

    localparam logic [GEN_W-1:0] LCG_M [NUM_GEN] =
        '{GEN_W'(M1), GEN_W'(M2), GEN_W'(M3)};
    localparam logic [MUL_W-1:0] LCG_A [NUM_GEN] =
        '{MUL_W'(A1), MUL_W'(A2), MUL_W'(A3)};
    localparam logic [GEN_W-1:0] LCG_C [NUM_GEN] =
        '{GEN_W'(C1), GEN_W'(C2), GEN_W'(C3)};
    // floor(2^33 / M): estimate is at most one below the true quotient
    localparam logic [Q_W-1:0] LCG_R [NUM_GEN] =
        '{Q_W'((64'd1 << RECIP_SHIFT) / M1),
          Q_W'((64'd1 << RECIP_SHIFT) / M2),
          Q_W'((64'd1 << RECIP_SHIFT) / M3)};

    // C1 plus a multiple of M1 above 2^31 keeps C1 - seed positive
    localparam logic [Y_W-1:0] SEED_OFS = Y_W'(C1 + 64'd8286 * M1);

    localparam logic [ENTRY_W-1:0] DEN = ENTRY_W'(M1 * M2);

    // floor(2^52 / (M1 * M2)): each 16-bit quotient digit comes out at most one low
    localparam logic [FRAC_R_W-1:0] FRAC_R =
        FRAC_R_W'((64'd1 << (FRAC_SHIFT + Q_W)) / (M1 * M2));

    typedef enum logic [1:0] {
        Y_LCG,
        Y_SEED,
        Y_SLOT
    } ysel_t;

    typedef enum logic [2:0] {
        JOB_SEED,
        JOB_PRE2,
        JOB_PRE3,
        JOB_FILL,
        JOB_DRAW,
        JOB_SLOT
    } job_t;

    typedef enum logic [1:0] {
        FP_QUOT,
        FP_REM,
        FP_FIX
    } frac_ph_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEED_LOAD,
        ST_LOAD,
        ST_QUOT,
        ST_REM,
        ST_FIX,
        ST_COPY2,
        ST_COPY3,
        ST_COMB,
        ST_FILL_WR,
        ST_SLOT_LOAD,
        ST_TBL_RD,
        ST_TBL_WR,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                seed_ld;
        logic                y_ld;
        ysel_t               y_sel;
        logic                q_ld;
        logic                r_ld;
        logic [NUM_GEN-1:0]  gen_wr;
        logic                copy2;
        logic                copy3;
        logic                comb_ld;
        logic                fill_clr;
        logic                fill_inc;
        logic                slot_ld;
        logic                tbl_rd;
        logic                tbl_wr;
        logic                wr_slot;
        logic                div_init;
        logic                div_step;
        logic                out_ld;
    } dp_cmd_t;

    typedef struct packed {
        logic seed_neg;
        logic fill_last;
        logic div_last;
    } dp_sts_t;

endpackage

/* hdl/tlcg_dpath.sv */
`timescale 1ns / 1ps
module tlcg_dpath #(
    parameter int TABLE_SIZE = tlcg_pkg::TABLE_SIZE_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic signed [tlcg_pkg::SEED_W-1:0]   seed,
    input  tlcg_pkg::dp_cmd_t                    cmd,
    output tlcg_pkg::dp_sts_t                    sts,
    output logic [tlcg_pkg::FRAC_W-1:0]          random_fraction
);

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int NG      = tlcg_pkg::NUM_GEN;
    localparam int GEN_W   = tlcg_pkg::GEN_W;
    localparam int Y_W     = tlcg_pkg::Y_W;
    localparam int Q_W     = tlcg_pkg::Q_W;
    localparam int R_W     = tlcg_pkg::R_W;
    localparam int PROD_W  = tlcg_pkg::PROD_W;
    localparam int ENTRY_W = tlcg_pkg::ENTRY_W;
    localparam int FRAC_W  = tlcg_pkg::FRAC_W;
    localparam int FPROD_W = tlcg_pkg::FPROD_W;
    localparam int NUM_W   = ENTRY_W + Q_W;
    localparam int G1      = tlcg_pkg::GEN1_IDX;
    localparam int G2      = tlcg_pkg::GEN2_IDX;
    localparam int G3      = tlcg_pkg::GEN3_IDX;

    logic signed [tlcg_pkg::SEED_W-1:0] seed_reg;
    logic [GEN_W-1:0]   gen_reg [NG];
    logic [Y_W-1:0]     y_reg   [NG];
    logic [Q_W-1:0]     q_reg   [NG];
    logic [R_W-1:0]     r_reg   [NG];
    logic [ENTRY_W-1:0] comb_reg;
    logic [IDX_W-1:0]   fill_idx_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic [ENTRY_W-1:0] rd_reg;
    logic [ENTRY_W-1:0] rem_reg;
    logic [Q_W-1:0]     fq_reg;
    logic [ENTRY_W:0]   fr_reg;
    logic [FRAC_W-1:0]  quo_reg;
    tlcg_pkg::frac_ph_t frac_ph_reg;
    logic               frac_lo_reg;
    logic [FRAC_W-1:0]  frac_reg;

    logic [ENTRY_W-1:0] tbl_mem [TABLE_SIZE];

    logic [Y_W-1:0]     lcg_y     [NG];
    logic [PROD_W-1:0]  recip_prod[NG];
    logic [Q_W-1:0]     quot_est  [NG];
    logic [Y_W-1:0]     rem_full  [NG];
    logic [GEN_W-1:0]   rem_fixed [NG];
    logic [Y_W-1:0]     seed_y;
    logic [Y_W-1:0]     slot_y;
    logic [GEN_W-1:0]   copy2_val;
    logic [GEN_W-1:0]   copy3_val;
    logic [ENTRY_W-1:0] comb_next;
    logic [Q_W:0]       slot_full;
    logic [IDX_W-1:0]   slot_next;
    logic [IDX_W-1:0]   wr_addr;
    logic [FPROD_W-1:0] frac_prod;
    logic [Q_W-1:0]     frac_q_est;
    logic [NUM_W-1:0]   frac_r_full;
    logic               frac_ge;
    logic [ENTRY_W-1:0] frac_rem_fix;
    logic [Q_W-1:0]     frac_q_fix;

    always_comb begin
        for (int i = 0; i < NG; i++) begin
            lcg_y[i]      = Y_W'(gen_reg[i]) * Y_W'(tlcg_pkg::LCG_A[i])
                          + Y_W'(tlcg_pkg::LCG_C[i]);
            recip_prod[i] = PROD_W'(y_reg[i]) * PROD_W'(tlcg_pkg::LCG_R[i]);
            quot_est[i]   = Q_W'(recip_prod[i] >> tlcg_pkg::RECIP_SHIFT);
            rem_full[i]   = y_reg[i] - Y_W'(q_reg[i]) * Y_W'(tlcg_pkg::LCG_M[i]);
            rem_fixed[i]  = (r_reg[i] >= R_W'(tlcg_pkg::LCG_M[i]))
                          ? GEN_W'(r_reg[i] - R_W'(tlcg_pkg::LCG_M[i]))
                          : GEN_W'(r_reg[i]);
        end
    end

    assign seed_y = tlcg_pkg::SEED_OFS - {seed_reg[tlcg_pkg::SEED_W-1], seed_reg};
    assign slot_y = Y_W'(TABLE_SIZE) * Y_W'(gen_reg[G3]);

    // generator one is below twice M2 and M3, so one subtract reduces it
    assign copy2_val = (gen_reg[G1] >= tlcg_pkg::LCG_M[G2])
                     ? gen_reg[G1] - tlcg_pkg::LCG_M[G2] : gen_reg[G1];
    assign copy3_val = (gen_reg[G1] >= tlcg_pkg::LCG_M[G3])
                     ? gen_reg[G1] - tlcg_pkg::LCG_M[G3] : gen_reg[G1];

    assign comb_next = ENTRY_W'(gen_reg[G1]) * ENTRY_W'(tlcg_pkg::LCG_M[G2])
                     + ENTRY_W'(gen_reg[G2]);

    always_comb begin
        slot_full = {1'b0, q_reg[G3]}
                  + (Q_W + 1)'(r_reg[G3] >= R_W'(tlcg_pkg::LCG_M[G3]));
        if (slot_full >= (Q_W + 1)'(TABLE_SIZE)) begin
            slot_next = IDX_W'(TABLE_SIZE - 1);
        end else begin
            slot_next = IDX_W'(slot_full);
        end
    end

    assign wr_addr = cmd.wr_slot ? slot_reg : fill_idx_reg;

    // entry * 2^32 / (M1 * M2) as two 16-bit digits: estimate, remainder, correct
    assign frac_prod    = FPROD_W'(rem_reg) * FPROD_W'(tlcg_pkg::FRAC_R);
    assign frac_q_est   = Q_W'(frac_prod >> tlcg_pkg::FRAC_SHIFT);
    assign frac_r_full  = {rem_reg, {Q_W{1'b0}}}
                        - NUM_W'(fq_reg) * NUM_W'(tlcg_pkg::DEN);
    assign frac_ge      = fr_reg >= (ENTRY_W + 1)'(tlcg_pkg::DEN);
    assign frac_rem_fix = frac_ge ? ENTRY_W'(fr_reg - (ENTRY_W + 1)'(tlcg_pkg::DEN))
                                  : ENTRY_W'(fr_reg);
    assign frac_q_fix   = fq_reg + Q_W'(frac_ge);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NG; i++) begin
                gen_reg[i] <= '0;
            end
            fill_idx_reg <= '0;
            frac_ph_reg  <= tlcg_pkg::FP_QUOT;
            frac_lo_reg  <= 1'b0;
        end else begin
            for (int i = 0; i < NG; i++) begin
                if (cmd.gen_wr[i]) begin
                    gen_reg[i] <= rem_fixed[i];
                end
            end
            if (cmd.copy2) begin
                gen_reg[G2] <= copy2_val;
            end
            if (cmd.copy3) begin
                gen_reg[G3] <= copy3_val;
            end
            if (cmd.fill_clr) begin
                fill_idx_reg <= '0;
            end else if (cmd.fill_inc) begin
                fill_idx_reg <= fill_idx_reg + IDX_W'(1);
            end
            if (cmd.div_init) begin
                frac_ph_reg <= tlcg_pkg::FP_QUOT;
                frac_lo_reg <= 1'b0;
            end else if (cmd.div_step) begin
                case (frac_ph_reg)
                    tlcg_pkg::FP_QUOT: frac_ph_reg <= tlcg_pkg::FP_REM;
                    tlcg_pkg::FP_REM:  frac_ph_reg <= tlcg_pkg::FP_FIX;
                    tlcg_pkg::FP_FIX: begin
                        frac_ph_reg <= tlcg_pkg::FP_QUOT;
                        frac_lo_reg <= 1'b1;
                    end
                    default:           frac_ph_reg <= tlcg_pkg::FP_QUOT;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.seed_ld) begin
            seed_reg <= seed;
        end
        if (cmd.y_ld) begin
            for (int i = 0; i < NG; i++) begin
                if (i == G1 && cmd.y_sel == tlcg_pkg::Y_SEED) begin
                    y_reg[i] <= seed_y;
                end else if (i == G3 && cmd.y_sel == tlcg_pkg::Y_SLOT) begin
                    y_reg[i] <= slot_y;
                end else begin
                    y_reg[i] <= lcg_y[i];
                end
            end
        end
        if (cmd.q_ld) begin
            for (int i = 0; i < NG; i++) begin
                q_reg[i] <= quot_est[i];
            end
        end
        if (cmd.r_ld) begin
            for (int i = 0; i < NG; i++) begin
                r_reg[i] <= R_W'(rem_full[i]);
            end
        end
        if (cmd.comb_ld) begin
            comb_reg <= comb_next;
        end
        if (cmd.slot_ld) begin
            slot_reg <= slot_next;
        end
        if (cmd.div_init) begin
            rem_reg <= rd_reg;
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            case (frac_ph_reg)
                tlcg_pkg::FP_QUOT: fq_reg <= frac_q_est;
                tlcg_pkg::FP_REM:  fr_reg <= (ENTRY_W + 1)'(frac_r_full);
                tlcg_pkg::FP_FIX: begin
                    rem_reg <= frac_rem_fix;
                    quo_reg <= {quo_reg[FRAC_W-Q_W-1:0], frac_q_fix};
                end
                default: begin
                end
            endcase
        end
        if (cmd.out_ld) begin
            frac_reg <= quo_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tbl_wr) begin
            tbl_mem[wr_addr] <= comb_reg;
        end
        if (cmd.tbl_rd) begin
            rd_reg <= tbl_mem[slot_reg];
        end
    end

    assign sts.seed_neg  = seed_reg[tlcg_pkg::SEED_W-1];
    assign sts.fill_last = (fill_idx_reg == IDX_W'(TABLE_SIZE - 1));
    assign sts.div_last  = frac_lo_reg && (frac_ph_reg == tlcg_pkg::FP_FIX);

    assign random_fraction = frac_reg;

`ifndef ASSERT_OFF
    gen_range_a: assert property (@(posedge aclk) disable iff (!aresetn)
        (gen_reg[G1] < tlcg_pkg::LCG_M[G1]) && (gen_reg[G2] < tlcg_pkg::LCG_M[G2])
        && (gen_reg[G3] < tlcg_pkg::LCG_M[G3]))
        else $error("generator state not reduced below its modulus");

    div_rem_a: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.div_init || cmd.div_step) |-> (rem_reg < tlcg_pkg::DEN))
        else $error("fraction divider remainder out of range");
`endif

endmodule

/* hdl/tlcg_ctrl.sv */
`timescale 1ns / 1ps
module tlcg_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  tlcg_pkg::dp_sts_t  sts,
    output tlcg_pkg::dp_cmd_t  cmd
);

    tlcg_pkg::state_t state_reg, state_next;
    tlcg_pkg::job_t   job_reg, job_next;
    logic             seeded_reg, seeded_next;
    logic             out_valid_reg, out_valid_next;

    function automatic logic [tlcg_pkg::NUM_GEN-1:0] lane_mask(tlcg_pkg::job_t job);
        logic [tlcg_pkg::NUM_GEN-1:0] mask;
        case (job)
            tlcg_pkg::JOB_SEED,
            tlcg_pkg::JOB_PRE2,
            tlcg_pkg::JOB_PRE3: mask = 3'b001;
            tlcg_pkg::JOB_FILL: mask = 3'b011;
            tlcg_pkg::JOB_DRAW: mask = 3'b111;
            default:            mask = 3'b000;
        endcase
        return mask;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tlcg_pkg::ST_IDLE;
            job_reg       <= tlcg_pkg::JOB_SEED;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        job_next    = job_reg;
        seeded_next = seeded_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        case (state_reg)
            tlcg_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.seed_ld = 1'b1;
                    state_next  = tlcg_pkg::ST_CHECK;
                end
            end
            tlcg_pkg::ST_CHECK: begin
                if (sts.seed_neg || !seeded_reg) begin
                    state_next = tlcg_pkg::ST_SEED_LOAD;
                end else begin
                    job_next   = tlcg_pkg::JOB_DRAW;
                    state_next = tlcg_pkg::ST_LOAD;
                end
            end
            tlcg_pkg::ST_SEED_LOAD: begin
                cmd.y_ld   = 1'b1;
                cmd.y_sel  = tlcg_pkg::Y_SEED;
                job_next   = tlcg_pkg::JOB_SEED;
                state_next = tlcg_pkg::ST_QUOT;
            end
            tlcg_pkg::ST_LOAD: begin
                cmd.y_ld   = 1'b1;
                cmd.y_sel  = tlcg_pkg::Y_LCG;
                state_next = tlcg_pkg::ST_QUOT;
            end
            tlcg_pkg::ST_QUOT: begin
                cmd.q_ld   = 1'b1;
                state_next = tlcg_pkg::ST_REM;
            end
            tlcg_pkg::ST_REM: begin
                cmd.r_ld   = 1'b1;
                state_next = tlcg_pkg::ST_FIX;
            end
            tlcg_pkg::ST_FIX: begin
                if (job_reg == tlcg_pkg::JOB_SLOT) begin
                    cmd.slot_ld = 1'b1;
                    state_next  = tlcg_pkg::ST_TBL_RD;
                end else begin
                    cmd.gen_wr = lane_mask(job_reg);
                    case (job_reg)
                        tlcg_pkg::JOB_SEED: begin
                            job_next   = tlcg_pkg::JOB_PRE2;
                            state_next = tlcg_pkg::ST_LOAD;
                        end
                        tlcg_pkg::JOB_PRE2: state_next = tlcg_pkg::ST_COPY2;
                        tlcg_pkg::JOB_PRE3: state_next = tlcg_pkg::ST_COPY3;
                        tlcg_pkg::JOB_FILL: state_next = tlcg_pkg::ST_COMB;
                        default:            state_next = tlcg_pkg::ST_SLOT_LOAD;
                    endcase
                end
            end
            tlcg_pkg::ST_COPY2: begin
                cmd.copy2  = 1'b1;
                job_next   = tlcg_pkg::JOB_PRE3;
                state_next = tlcg_pkg::ST_LOAD;
            end
            tlcg_pkg::ST_COPY3: begin
                cmd.copy3    = 1'b1;
                cmd.fill_clr = 1'b1;
                job_next     = tlcg_pkg::JOB_FILL;
                state_next   = tlcg_pkg::ST_LOAD;
            end
            tlcg_pkg::ST_COMB: begin
                cmd.comb_ld = 1'b1;
                state_next  = tlcg_pkg::ST_FILL_WR;
            end
            tlcg_pkg::ST_FILL_WR: begin
                cmd.tbl_wr   = 1'b1;
                cmd.fill_inc = 1'b1;
                state_next   = tlcg_pkg::ST_LOAD;
                if (sts.fill_last) begin
                    seeded_next = 1'b1;
                    job_next    = tlcg_pkg::JOB_DRAW;
                end
            end
            tlcg_pkg::ST_SLOT_LOAD: begin
                // scale generator three for the slot, latch the refill value
                cmd.y_ld    = 1'b1;
                cmd.y_sel   = tlcg_pkg::Y_SLOT;
                cmd.comb_ld = 1'b1;
                job_next    = tlcg_pkg::JOB_SLOT;
                state_next  = tlcg_pkg::ST_QUOT;
            end
            tlcg_pkg::ST_TBL_RD: begin
                cmd.tbl_rd = 1'b1;
                state_next = tlcg_pkg::ST_TBL_WR;
            end
            tlcg_pkg::ST_TBL_WR: begin
                cmd.tbl_wr   = 1'b1;
                cmd.wr_slot  = 1'b1;
                cmd.div_init = 1'b1;
                state_next   = tlcg_pkg::ST_DIV;
            end
            tlcg_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = tlcg_pkg::ST_OUT;
                end
            end
            tlcg_pkg::ST_OUT: begin
                // hold until the previous result has been taken
                if (!out_valid_reg || m_ready) begin
                    cmd.out_ld = 1'b1;
                    state_next = tlcg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tlcg_pkg::ST_IDLE;
            end
        endcase
        out_valid_next = cmd.out_ld | (out_valid_reg & ~m_ready);
    end

    assign m_valid = out_valid_reg;

`ifndef ASSERT_OFF
    no_overwrite_a: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_ld |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten before it was taken");

    seeded_sticky_a: assert property (@(posedge aclk) disable iff (!aresetn)
        seeded_reg |=> seeded_reg)
        else $error("seeded flag dropped without reset");
`endif

endmodule

/* hdl/three_lcg_shuffled_uniform_rng.sv */
// A plain draw steps the generators and reduces the slot choice by reciprocal
// reduction, reads and refills that table entry, and divides the entry read into
// the fraction; a reseed also reduces the seed and fills the table. s_axis_tready
// is high only while idle, so a new request waits until the last result is loaded.
// Reset: aresetn clears the controller and generators; the shuffle table is not
// cleared, and the first request after reset always reseeds and fills it.
`timescale 1ns / 1ps
module three_lcg_shuffled_uniform_rng #(
    parameter int TABLE_SIZE = tlcg_pkg::TABLE_SIZE_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic signed [tlcg_pkg::SEED_W-1:0]  s_axis_tdata,  // [31:0] seed
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [tlcg_pkg::FRAC_W-1:0]         m_axis_tdata   // [31:0] random_fraction
);

    tlcg_pkg::dp_cmd_t cmd;
    tlcg_pkg::dp_sts_t sts;

    tlcg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tlcg_dpath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .seed            (s_axis_tdata),
        .cmd             (cmd),
        .sts             (sts),
        .random_fraction (m_axis_tdata)
    );

endmodule
